/* src/x86d_pkg.sv */
`default_nettype none

package x86d_pkg;

    // Opcode bit patterns, matched on the leading bits of the opcode byte
    localparam logic [5:0] PAT_MOV_RM  = 6'b100010;   // 88-8B
    localparam logic [3:0] PAT_MOV_IR  = 4'b1011;     // B0-BF
    localparam logic [6:0] PAT_MOV_IRM = 7'b1100011;  // C6-C7
    localparam logic [5:0] PAT_MOV_ACC = 6'b101000;   // A0-A3
    localparam logic [5:0] PAT_ADD_RM  = 6'b000000;   // 00-03
    localparam logic [5:0] PAT_GRP     = 6'b100000;   // 80-83
    localparam logic [6:0] PAT_ADD_AI  = 7'b0000010;  // 04-05
    localparam logic [5:0] PAT_SUB_RM  = 6'b001010;   // 28-2B
    localparam logic [6:0] PAT_SUB_AI  = 7'b0010110;  // 2C-2D
    localparam logic [5:0] PAT_CMP_RM  = 6'b001110;   // 38-3B
    localparam logic [6:0] PAT_CMP_AI  = 7'b0011110;  // 3C-3D
    localparam logic [7:0] OPC_JNZ     = 8'b01110101; // 75

    // Operation kinds
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_CMP = 3'd3;
    localparam logic [2:0] OP_JNZ = 3'd4;

    // Operand forms
    localparam logic [2:0] FORM_REG_REG = 3'd0;
    localparam logic [2:0] FORM_MEM_REG = 3'd1;
    localparam logic [2:0] FORM_REG_IMM = 3'd2;
    localparam logic [2:0] FORM_MEM_IMM = 3'd3;
    localparam logic [2:0] FORM_IMM     = 3'd4;

    // mod field codes
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    // r/m code that means a direct address under mod 0
    localparam logic [2:0] RM_DIRECT = 3'd6;

    // Immediate group sub-ops
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    localparam int unsigned IN_BYTES  = 1;
    localparam int unsigned OUT_BITS  = 51;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_MODRM  = 2'd1,
        PH_DISP   = 2'd2,
        PH_IMM    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CL_BAD    = 3'd0,
        CL_RM     = 3'd1,
        CL_MOVIR  = 3'd2,
        CL_MOVIRM = 3'd3,
        CL_ACCMEM = 3'd4,
        CL_ACCIMM = 3'd5,
        CL_GRP    = 3'd6,
        CL_JNZ    = 3'd7
    } class_t;

    // Decoder state carried between code bytes
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [1:0]  bytes_left;
    } st_t;

    // Decoded record; op_kind sits in the lowest bits
    typedef struct packed {
        logic        bad_opcode;
        logic        imm_is_byte;
        logic [15:0] immediate;
        logic        abs_addr;
        logic [15:0] displacement;
        logic [1:0]  mode_field;
        logic [2:0]  rm_field;
        logic [2:0]  reg_field;
        logic        word_op;
        logic        reg_is_dest;
        logic [2:0]  operand_form;
        logic [2:0]  op_kind;
    } rec_t;

endpackage

`default_nettype wire

/* src/x86d_decode.sv */
`default_nettype none

module x86d_decode (
    input  wire logic [7:0]     code_byte,
    input  wire x86d_pkg::st_t  st,
    output x86d_pkg::st_t       st_next,
    output logic                emit,
    output x86d_pkg::rec_t      rec
);

    function automatic x86d_pkg::class_t classify(input logic [7:0] op);
        x86d_pkg::class_t c;
        c = x86d_pkg::CL_BAD;
        if (op[7:2] == x86d_pkg::PAT_MOV_RM || op[7:2] == x86d_pkg::PAT_ADD_RM ||
            op[7:2] == x86d_pkg::PAT_SUB_RM || op[7:2] == x86d_pkg::PAT_CMP_RM) begin
            c = x86d_pkg::CL_RM;
        end else if (op[7:4] == x86d_pkg::PAT_MOV_IR) begin
            c = x86d_pkg::CL_MOVIR;
        end else if (op[7:1] == x86d_pkg::PAT_MOV_IRM) begin
            c = x86d_pkg::CL_MOVIRM;
        end else if (op[7:2] == x86d_pkg::PAT_MOV_ACC) begin
            c = x86d_pkg::CL_ACCMEM;
        end else if (op[7:1] == x86d_pkg::PAT_ADD_AI || op[7:1] == x86d_pkg::PAT_SUB_AI ||
                     op[7:1] == x86d_pkg::PAT_CMP_AI) begin
            c = x86d_pkg::CL_ACCIMM;
        end else if (op[7:2] == x86d_pkg::PAT_GRP) begin
            c = x86d_pkg::CL_GRP;
        end else if (op == x86d_pkg::OPC_JNZ) begin
            c = x86d_pkg::CL_JNZ;
        end
        return c;
    endfunction

    function automatic logic has_modrm(input x86d_pkg::class_t c);
        return c == x86d_pkg::CL_RM || c == x86d_pkg::CL_MOVIRM || c == x86d_pkg::CL_GRP;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] op, input logic [7:0] mrm);
        x86d_pkg::class_t c;
        logic [1:0] n;
        c = classify(op);
        n = 2'd0;
        if (c == x86d_pkg::CL_ACCMEM) begin
            n = 2'd2;
        end else if (has_modrm(c)) begin
            if (mrm[7:6] == x86d_pkg::MOD_DISP8) begin
                n = 2'd1;
            end else if (mrm[7:6] == x86d_pkg::MOD_DISP16) begin
                n = 2'd2;
            end else if (mrm[7:6] == x86d_pkg::MOD_NODISP && mrm[2:0] == x86d_pkg::RM_DIRECT) begin
                n = 2'd2;
            end
        end
        return n;
    endfunction

    function automatic logic [1:0] imm_bytes(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        unique case (classify(op))
            x86d_pkg::CL_MOVIR:  n = op[3] ? 2'd2 : 2'd1;
            x86d_pkg::CL_MOVIRM,
            x86d_pkg::CL_ACCIMM: n = op[0] ? 2'd2 : 2'd1;
            x86d_pkg::CL_GRP:    n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
            x86d_pkg::CL_JNZ:    n = 2'd1;
            default:             n = 2'd0;
        endcase
        return n;
    endfunction

    // add/sub/cmp carry the group sub-op numbering in bits 5:3
    function automatic logic [2:0] kind_of(input logic [7:0] op);
        logic [2:0] k;
        if (op[7:2] == x86d_pkg::PAT_MOV_RM || op[7:2] == x86d_pkg::PAT_MOV_ACC) begin
            k = x86d_pkg::OP_MOV;
        end else if (op[5:3] == x86d_pkg::GRP_ADD) begin
            k = x86d_pkg::OP_ADD;
        end else if (op[5:3] == x86d_pkg::GRP_SUB) begin
            k = x86d_pkg::OP_SUB;
        end else begin
            k = x86d_pkg::OP_CMP;
        end
        return k;
    endfunction

    function automatic x86d_pkg::rec_t build(input logic [7:0] op, input logic [7:0] mrm,
                                             input logic [15:0] dsp, input logic [15:0] imv);
        x86d_pkg::rec_t r;
        x86d_pkg::class_t c;
        logic [1:0] md;
        logic [2:0] rg;
        logic [2:0] rmv;
        c   = classify(op);
        md  = mrm[7:6];
        rg  = mrm[5:3];
        rmv = mrm[2:0];
        r = '0;
        r.displacement = dsp;
        r.immediate    = imv;
        r.imm_is_byte  = (imm_bytes(op) == 2'd1);
        if (has_modrm(c)) begin
            r.reg_field  = rg;
            r.rm_field   = rmv;
            r.mode_field = md;
            r.abs_addr   = (md == x86d_pkg::MOD_NODISP && rmv == x86d_pkg::RM_DIRECT);
            r.word_op    = op[0];
        end
        unique case (c)
            x86d_pkg::CL_RM: begin
                r.op_kind      = kind_of(op);
                r.operand_form = (md == x86d_pkg::MOD_REG) ? x86d_pkg::FORM_REG_REG
                                                           : x86d_pkg::FORM_MEM_REG;
                r.reg_is_dest  = op[1];
            end
            x86d_pkg::CL_MOVIRM: begin
                r.op_kind      = x86d_pkg::OP_MOV;
                r.operand_form = (md == x86d_pkg::MOD_REG) ? x86d_pkg::FORM_REG_IMM
                                                           : x86d_pkg::FORM_MEM_IMM;
            end
            x86d_pkg::CL_GRP: begin
                if (rg == x86d_pkg::GRP_ADD) begin
                    r.op_kind = x86d_pkg::OP_ADD;
                end else if (rg == x86d_pkg::GRP_SUB) begin
                    r.op_kind = x86d_pkg::OP_SUB;
                end else if (rg == x86d_pkg::GRP_CMP) begin
                    r.op_kind = x86d_pkg::OP_CMP;
                end else begin
                    r.bad_opcode = 1'b1;
                end
                r.operand_form = (md == x86d_pkg::MOD_REG) ? x86d_pkg::FORM_REG_IMM
                                                           : x86d_pkg::FORM_MEM_IMM;
            end
            x86d_pkg::CL_MOVIR: begin
                r.operand_form = x86d_pkg::FORM_REG_IMM;
                r.reg_is_dest  = 1'b1;
                r.word_op      = op[3];
                r.reg_field    = op[2:0];
                r.mode_field   = x86d_pkg::MOD_REG;
            end
            x86d_pkg::CL_ACCIMM: begin
                r.op_kind      = kind_of(op);
                r.operand_form = x86d_pkg::FORM_REG_IMM;
                r.reg_is_dest  = 1'b1;
                r.word_op      = op[0];
                r.mode_field   = x86d_pkg::MOD_REG;
            end
            x86d_pkg::CL_ACCMEM: begin
                r.operand_form = x86d_pkg::FORM_MEM_REG;
                r.reg_is_dest  = ~op[1];
                r.word_op      = op[0];
                r.rm_field     = x86d_pkg::RM_DIRECT;
                r.mode_field   = x86d_pkg::MOD_NODISP;
                r.abs_addr     = 1'b1;
            end
            x86d_pkg::CL_JNZ: begin
                r.op_kind      = x86d_pkg::OP_JNZ;
                r.operand_form = x86d_pkg::FORM_IMM;
            end
            default: begin
                r.bad_opcode = 1'b1;
            end
        endcase
        return r;
    endfunction

    logic [7:0]  op_v;
    logic [7:0]  modrm_v;
    logic [15:0] disp_v;
    logic [15:0] imm_v;
    logic        adv;
    logic        skip_disp;
    logic        skip_imm;
    logic [1:0]  nd;
    logic [1:0]  ni;

    always_comb begin
        st_next   = st;
        emit      = 1'b0;
        rec       = '0;
        adv       = 1'b0;
        skip_disp = 1'b0;
        skip_imm  = 1'b0;
        op_v      = st.opcode;
        modrm_v   = st.modrm;
        disp_v    = st.disp;
        imm_v     = st.imm;

        unique case (st.phase)
            x86d_pkg::PH_MODRM: begin
                modrm_v = code_byte;
                adv     = 1'b1;
            end
            x86d_pkg::PH_DISP: begin
                if (st.bytes_left == 2'd2) begin
                    disp_v             = {8'h00, code_byte};
                    st_next.bytes_left = 2'd1;
                end else begin
                    if (disp_bytes(op_v, modrm_v) == 2'd2) begin
                        disp_v = {code_byte, st.disp[7:0]};
                    end else begin
                        disp_v = {{8{code_byte[7]}}, code_byte};
                    end
                    st_next.bytes_left = 2'd0;
                    adv       = 1'b1;
                    skip_disp = 1'b1;
                end
            end
            x86d_pkg::PH_IMM: begin
                if (st.bytes_left == 2'd2) begin
                    imm_v              = {8'h00, code_byte};
                    st_next.bytes_left = 2'd1;
                end else begin
                    if (imm_bytes(op_v) == 2'd2) begin
                        imm_v = {code_byte, st.imm[7:0]};
                    end else begin
                        imm_v = {8'h00, code_byte};
                    end
                    st_next.bytes_left = 2'd0;
                    adv       = 1'b1;
                    skip_disp = 1'b1;
                    skip_imm  = 1'b1;
                end
            end
            x86d_pkg::PH_OPCODE: begin
                op_v               = code_byte;
                modrm_v            = 8'h00;
                disp_v             = 16'h0000;
                imm_v              = 16'h0000;
                st_next.bytes_left = 2'd0;
                if (classify(code_byte) == x86d_pkg::CL_BAD) begin
                    emit           = 1'b1;
                    rec.bad_opcode = 1'b1;
                end else if (has_modrm(classify(code_byte))) begin
                    st_next.phase = x86d_pkg::PH_MODRM;
                end else begin
                    adv = 1'b1;
                end
            end
            default: begin
                st_next.phase = x86d_pkg::PH_OPCODE;
            end
        endcase

        st_next.opcode = op_v;
        st_next.modrm  = modrm_v;
        st_next.disp   = disp_v;
        st_next.imm    = imm_v;

        nd = disp_bytes(op_v, modrm_v);
        ni = imm_bytes(op_v);

        // Move on to the next stage that still expects bytes, or finish
        if (adv) begin
            if (!skip_disp && nd != 2'd0) begin
                st_next.phase      = x86d_pkg::PH_DISP;
                st_next.bytes_left = nd;
            end else if (!skip_imm && ni != 2'd0) begin
                st_next.phase      = x86d_pkg::PH_IMM;
                st_next.bytes_left = ni;
            end else begin
                emit               = 1'b1;
                rec                = build(op_v, modrm_v, disp_v, imm_v);
                st_next.phase      = x86d_pkg::PH_OPCODE;
                st_next.bytes_left = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/x86_16_instruction_decoder.sv */
`default_nettype none

// Decoder for a subset of the 16-bit x86 instruction set (mov, add, sub, cmp in their
// reg/mem, immediate and accumulator forms, the 80-83 immediate group, and jnz). Code
// bytes enter on s_ one word per cycle unless m_ stalls; after the last byte of an
// instruction one decoded record leaves on the m_ channel. A byte that is not a known
// opcode yields a record at once with bad_opcode set and every other field zero, and
// decoding resumes at the next byte; an unknown group sub-op consumes the whole
// instruction and sets bad_opcode. Throughput is one code byte per clock with no
// bubbles while m_tready is high: each byte is held in an input register, decoded
// combinationally against the small phase state, and its record (if any) loaded into
// the output register, from which it leaves on m_. The output register drains while
// the next byte is decoded, so a stalled m_tready only stops the input once both the
// output register and the input register are full.

module x86_16_instruction_decoder (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // s_tdata: code_byte[7:0]
    input  wire logic [x86d_pkg::IN_BYTES*8-1:0]        s_tdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // m_tdata: op_kind[2:0], operand_form[5:3], reg_is_dest[6], word_op[7],
    // reg_field[10:8], rm_field[13:11], mode_field[15:14], displacement[31:16],
    // abs_addr[32], immediate[48:33], imm_is_byte[49], bad_opcode[50], zero above
    output logic [x86d_pkg::OUT_BYTES*8-1:0]            m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready
);

    logic           in_valid_reg;
    logic           in_valid_next;
    logic [7:0]     in_byte_reg;
    x86d_pkg::st_t  st_reg;
    x86d_pkg::st_t  st_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    x86d_pkg::rec_t out_rec_reg;

    logic           dec_emit;
    x86d_pkg::rec_t dec_rec;
    logic           can_step;
    logic           step;
    logic           in_fire;

    x86d_decode u_decode (
        .code_byte (in_byte_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .emit      (dec_emit),
        .rec       (dec_rec)
    );

    // Decode the held byte whenever the output register is free or being drained
    assign can_step = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && can_step;
    assign s_tready = !in_valid_reg || can_step;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        if (can_step) begin
            out_valid_next = step && dec_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            st_reg.phase       <= x86d_pkg::PH_OPCODE;
            st_reg.opcode      <= 8'h00;
            st_reg.modrm       <= 8'h00;
            st_reg.disp        <= 16'h0000;
            st_reg.imm         <= 16'h0000;
            st_reg.bytes_left  <= 2'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step) begin
                st_reg <= st_next;
            end
        end
    end

    // Payload: capture the byte on accept, load the record when one is produced
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_tdata[7:0];
        end
        if (step && dec_emit) begin
            out_rec_reg <= dec_rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(x86d_pkg::OUT_BYTES*8 - x86d_pkg::OUT_BITS){1'b0}}, out_rec_reg};

endmodule

`default_nettype wire

/* src/x86d_checker.sv */
`default_nettype none

module x86d_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tready,
    input wire logic [x86d_pkg::OUT_BYTES*8-1:0]    m_tdata,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready
);

    // Hold a stalled word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or dropped");

    // Reset drops any pending result and frees the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked right after reset");

    // A rejected opcode carries no operation
    a_bad_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[50] |-> m_tdata[2:0] == x86d_pkg::OP_MOV)
        else $error("bad opcode record with nonzero op_kind");

    // jnz is always a byte immediate
    a_jnz_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == x86d_pkg::OP_JNZ |->
            m_tdata[5:3] == x86d_pkg::FORM_IMM && m_tdata[49])
        else $error("jnz record with wrong operand form");

    // A direct address only comes with mod 0 and r/m 6
    a_direct_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |->
            m_tdata[15:14] == x86d_pkg::MOD_NODISP && m_tdata[13:11] == x86d_pkg::RM_DIRECT)
        else $error("direct address flag with wrong mod or r/m");

endmodule

bind x86_16_instruction_decoder x86d_checker u_x86d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
